// ===== rtl/log_grid_bilinear_table_interp_unit_macros.svh =====
// assertion helpers for the rtl
`ifndef LOG_GRID_BILINEAR_TABLE_INTERP_UNIT_MACROS_SVH
`define LOG_GRID_BILINEAR_TABLE_INTERP_UNIT_MACROS_SVH

// cond must never be seen at a clock edge out of reset
`define LGBI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define LGBI_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lgbi_pkg.sv =====
package lgbi_pkg;

  localparam int DATA_W     = 24;
  localparam int PTS_W      = 7;
  localparam int IDX_W      = 12;
  localparam int PHASE_W    = 8;
  localparam int REQ_W      = 2;
  localparam int QTY_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CLAMP_W    = 11;

  localparam int MAX_DENSITY_POINTS_DEF = 64;
  localparam int MAX_TEMP_POINTS_DEF    = 64;
  localparam int NUM_QUANTITIES_DEF     = 4;
  localparam int FRAC_BITS_DEF          = 16;

  // accept register to result register
  localparam int PIPE_LAT  = 11;
  localparam int OUT_DEPTH = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_WR_VALUE = 2'd0,
    REQ_WR_PHASE = 2'd1,
    REQ_INTERP   = 2'd2,
    REQ_PHASE    = 2'd3
  } req_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DENSITY_START = 3'd0,
    CFG_TEMP_START    = 3'd1,
    CFG_DENSITY_INV   = 3'd2,
    CFG_TEMP_INV      = 3'd3,
    CFG_DENSITY_PTS   = 3'd4,
    CFG_TEMP_PTS      = 3'd5,
    CFG_PHASE_PRESENT = 3'd6
  } cfg_reg_e_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [QTY_W-1:0]         quantity;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic [PHASE_W-1:0]       entry_phase;
    logic signed [DATA_W-1:0] log_density;
    logic signed [DATA_W-1:0] log_temp;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interp_value;
    logic [PHASE_W-1:0]       phase_code;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [DATA_W-1:0]    wdata;
  } cfg_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] density_start;
    logic signed [DATA_W-1:0] temp_start;
    logic [DATA_W-1:0]        density_inv;
    logic [DATA_W-1:0]        temp_inv;
    logic [PTS_W-1:0]         density_pts;
    logic [PTS_W-1:0]         temp_pts;
    logic                     phase_on;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    density_start: '0,
    temp_start:    '0,
    density_inv:   24'd65536,
    temp_inv:      24'd65536,
    density_pts:   7'd2,
    temp_pts:      7'd2,
    phase_on:      1'b0
  };

  typedef struct packed {
    logic   valid;
    req_e_t req;
    logic [QTY_W-1:0] qty;
  } item_ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic [PHASE_W-1:0]       entry_phase;
  } wr_fields_t;

  function automatic logic [CLAMP_W-1:0] clamp_points(input logic [PTS_W-1:0] n,
                                                      input logic [CLAMP_W-1:0] maxn);
    logic [CLAMP_W-1:0] nx;
    nx = CLAMP_W'(n);
    if (nx < CLAMP_W'(2)) begin
      return CLAMP_W'(2);
    end else if (nx > maxn) begin
      return maxn;
    end
    return nx;
  endfunction

endpackage

// ===== rtl/lgbi_chan_if.sv =====
interface lgbi_chan_if #(
  parameter type beat_t = logic
);
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lgbi_axis_map.sv =====
module lgbi_axis_map
  import lgbi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int IW        = 6,
  parameter int NW        = 7
) (
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] q,
  input  logic signed [DATA_W-1:0] start,
  input  logic [DATA_W-1:0]        step_inv,
  input  logic [NW-1:0]            n,
  output logic [IW-1:0]            cell_idx,
  output logic [FRAC_BITS:0]       frac,
  output logic [IW-1:0]            near_idx
);

  localparam int PW = 16 + FRAC_BITS;
  localparam int SH = 32 - FRAC_BITS;
  localparam int MW = 2 * DATA_W;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);

  logic signed [DATA_W:0] diff;
  logic [DATA_W-1:0]      d_r;
  logic [MW-1:0]          prod_r;
  logic [PW-1:0]          pos, top_pos, pos_r;
  logic [NW-1:0]          n_m1, n_m2;
  logic [IW-1:0]          i_raw, i_cl;
  logic [PW-1:0]          fr_full;
  logic [FRAC_BITS:0]     fr;
  logic [PW:0]            near_sum;
  logic [IW:0]            near_raw;
  logic [IW-1:0]          near_cl;

  assign diff    = (DATA_W+1)'(q) - (DATA_W+1)'(start);
  assign n_m1    = n - NW'(1);
  assign n_m2    = n - NW'(2);
  assign top_pos = PW'(n_m1) << FRAC_BITS;
  assign pos     = prod_r[MW-1:SH];

  // cell below the point, clamped so the upper neighbour stays on the grid
  assign i_raw   = pos_r[FRAC_BITS +: IW];
  assign i_cl    = (NW'(i_raw) > n_m2) ? IW'(n_m2) : i_raw;
  assign fr_full = pos_r - (PW'(i_cl) << FRAC_BITS);
  assign fr      = (fr_full > PW'(ONE)) ? ONE : fr_full[FRAC_BITS:0];

  // nearest grid line
  assign near_sum = {1'b0, pos_r} + HALF;
  assign near_raw = near_sum[FRAC_BITS +: IW+1];
  assign near_cl  = ((NW+1)'(near_raw) > (NW+1)'(n_m1)) ? IW'(n_m1) : near_raw[IW-1:0];

  always_ff @(posedge clk) begin
    d_r      <= diff[DATA_W] ? '0 : diff[DATA_W-1:0];
    prod_r   <= {{DATA_W{1'b0}}, d_r} * {{DATA_W{1'b0}}, step_inv};
    pos_r    <= (pos > top_pos) ? top_pos : pos;
    cell_idx <= i_cl;
    frac     <= fr;
    near_idx <= near_cl;
  end

endmodule

// ===== rtl/lgbi_table_mem.sv =====
module lgbi_table_mem
  import lgbi_pkg::*;
#(
  parameter int MAX_DENSITY_POINTS = MAX_DENSITY_POINTS_DEF,
  parameter int MAX_TEMP_POINTS    = MAX_TEMP_POINTS_DEF,
  parameter int NUM_QUANTITIES     = NUM_QUANTITIES_DEF,
  parameter int IW                 = 6,
  parameter int NW                 = 7
) (
  input  logic                     clk,
  input  item_ctl_t                ctl_s4,
  input  item_ctl_t                ctl_s6,
  input  wr_fields_t               wr_s4,
  input  logic [IW-1:0]            cell_d,
  input  logic [IW-1:0]            cell_t,
  input  logic [IW-1:0]            near_d,
  input  logic [IW-1:0]            near_t,
  input  logic [NW-1:0]            nt,
  output logic signed [DATA_W-1:0] corner [4],
  output logic [PHASE_W-1:0]       phase_rd
);

  localparam int GRID = MAX_DENSITY_POINTS * MAX_TEMP_POINTS;
  localparam int GW   = $clog2(GRID);
  localparam int AW   = $clog2(NUM_QUANTITIES * GRID);
  localparam int VDEPTH = NUM_QUANTITIES * GRID;

  logic [GW-1:0]  base_c, ph_c;
  logic [QTY_W-1:0] qsel;
  logic           idx_ok, wok_v, wok_p;

  logic [GW-1:0]  base_r, ph_ra_r, wa_pre_r;
  logic [AW-1:0]  qoff_r;
  logic [NW-1:0]  nt_r;
  logic           wok_v_r, wok_p_r, wok_v6_r, wok_p6_r;
  logic signed [DATA_W-1:0] wval_r, wval6_r;
  logic [PHASE_W-1:0]       wph_r, wph6_r;

  logic [AW-1:0]  addr_r [4];
  logic [AW-1:0]  wa_r;
  logic [GW-1:0]  ph_ra6_r, ph_wa6_r;
  logic [GW-1:0]  offs [4];

  logic we_v, we_p;
  logic [PHASE_W-1:0] pmem [GRID];

  assign base_c = GW'(cell_d) * GW'(nt) + GW'(cell_t);
  assign ph_c   = GW'(near_d) * GW'(nt) + GW'(near_t);
  assign qsel   = (32'(ctl_s4.qty) < NUM_QUANTITIES) ? ctl_s4.qty : '0;
  assign idx_ok = 32'(wr_s4.entry_index) < GRID;
  assign wok_v  = (ctl_s4.req == REQ_WR_VALUE) && idx_ok &&
                  (32'(ctl_s4.qty) < NUM_QUANTITIES);
  assign wok_p  = (ctl_s4.req == REQ_WR_PHASE) && idx_ok;

  // corner order: (i,j) (i,j+1) (i+1,j) (i+1,j+1)
  assign offs[0] = '0;
  assign offs[1] = GW'(1);
  assign offs[2] = GW'(nt_r);
  assign offs[3] = GW'(nt_r) + GW'(1);

  always_ff @(posedge clk) begin
    base_r   <= base_c;
    ph_ra_r  <= ph_c;
    wa_pre_r <= GW'(wr_s4.entry_index);
    qoff_r   <= AW'(qsel) * AW'(GRID);
    nt_r     <= nt;
    wok_v_r  <= wok_v;
    wok_p_r  <= wok_p;
    wval_r   <= wr_s4.entry_value;
    wph_r    <= wr_s4.entry_phase;

    for (int k = 0; k < 4; k++) begin
      addr_r[k] <= qoff_r + AW'(base_r) + AW'(offs[k]);
    end
    wa_r     <= qoff_r + AW'(wa_pre_r);
    ph_ra6_r <= ph_ra_r;
    ph_wa6_r <= wa_pre_r;
    wok_v6_r <= wok_v_r;
    wok_p6_r <= wok_p_r;
    wval6_r  <= wval_r;
    wph6_r   <= wph_r;
  end

  // writes take the same slot as reads so request order is kept
  assign we_v = ctl_s6.valid && wok_v6_r;
  assign we_p = ctl_s6.valid && wok_p6_r;

  for (genvar k = 0; k < 4; k++) begin : g_copy
    logic signed [DATA_W-1:0] vmem [VDEPTH];

    always_ff @(posedge clk) begin
      if (we_v) begin
        vmem[wa_r] <= wval6_r;
      end
      corner[k] <= vmem[addr_r[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (we_p) begin
      pmem[ph_wa6_r] <= wph6_r;
    end
    phase_rd <= pmem[ph_ra6_r];
  end

endmodule

// ===== rtl/lgbi_blend.sv =====
module lgbi_blend
  import lgbi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] corner [4],
  input  logic [FRAC_BITS:0]       t,
  input  logic [FRAC_BITS:0]       u,
  output logic signed [DATA_W-1:0] result
);

  localparam int MD  = (FRAC_BITS > 19) ? (2 * FRAC_BITS - 39) : 0;
  localparam int TOT = 2 * FRAC_BITS - MD;
  localparam int MW  = DATA_W + FRAC_BITS + 2;
  localparam int AV  = MW + 1 - MD;
  localparam int HB  = AV - 16;
  localparam int HW  = HB + FRAC_BITS + 2;
  localparam int LW  = 17 + FRAC_BITS + 2;
  localparam int SW  = HW + 18;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic signed [FRAC_BITS+1:0] wt0, wt1, wu0, wu1;
  logic signed [MW-1:0]  m_r [4];
  logic [FRAC_BITS:0]    u1_r, u2_r;
  logic signed [MW:0]    sa, sb;
  logic signed [AV-1:0]  a_r, b_r;
  logic signed [HB-1:0]  ah, bh;
  logic signed [16:0]    al, bl;
  logic signed [HW-1:0]  qh_r [2];
  logic signed [LW-1:0]  ql_r [2];
  logic signed [SW-1:0]  sum;

  assign wt0 = $signed({1'b0, ONE - t});
  assign wt1 = $signed({1'b0, t});
  assign wu0 = $signed({1'b0, ONE - u2_r});
  assign wu1 = $signed({1'b0, u2_r});

  assign sa = (MW+1)'(m_r[0]) + (MW+1)'(m_r[2]);
  assign sb = (MW+1)'(m_r[1]) + (MW+1)'(m_r[3]);

  assign ah = a_r[AV-1:16];
  assign bh = b_r[AV-1:16];
  assign al = $signed({1'b0, a_r[15:0]});
  assign bl = $signed({1'b0, b_r[15:0]});

  assign sum = ((SW'(qh_r[0]) + SW'(qh_r[1])) <<< 16) + SW'(ql_r[0]) + SW'(ql_r[1]) +
               (SW'(1) <<< (TOT - 1));

  always_ff @(posedge clk) begin
    // along density
    m_r[0] <= corner[0] * wt0;
    m_r[1] <= corner[1] * wt0;
    m_r[2] <= corner[2] * wt1;
    m_r[3] <= corner[3] * wt1;
    u1_r   <= u;

    a_r  <= AV'(sa >>> MD);
    b_r  <= AV'(sb >>> MD);
    u2_r <= u1_r;

    // along temperature, split in high and low parts
    qh_r[0] <= ah * wu0;
    qh_r[1] <= bh * wu1;
    ql_r[0] <= al * wu0;
    ql_r[1] <= bl * wu1;

    result <= DATA_W'(sum >>> TOT);
  end

endmodule

// ===== rtl/lgbi_out_fifo.sv =====
`include "log_grid_bilinear_table_interp_unit_macros.svh"

module lgbi_out_fifo
  import lgbi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  logic      push,
  input  out_beat_t push_beat,
  output logic      credit_ok,
  lgbi_chan_if.source out_ch
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  out_beat_t        buf_r [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt, credit_r, credit_nxt;
  logic             pop;

  assign out_ch.valid = (fill_r != '0);
  assign out_ch.data  = buf_r[rd_ptr_r];
  assign pop          = out_ch.valid && out_ch.ready;
  // every beat in flight already owns a slot
  assign credit_ok    = credit_r < CNT_W'(OUT_DEPTH);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + CNT_W'(push) - CNT_W'(pop);
    credit_nxt = credit_r + CNT_W'(take) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      credit_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      credit_r <= credit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_beat;
    end
  end

  `LGBI_NEVER(a_no_overflow, push && !pop && (fill_r == CNT_W'(OUT_DEPTH)), "result fifo overflow")
  `LGBI_NEVER(a_fill_in_credit, fill_r > credit_r, "more results stored than accepted")
  `LGBI_IMPLIES(a_take_has_room, take, credit_r < CNT_W'(OUT_DEPTH), "beat taken without room")

endmodule

// ===== rtl/log_grid_bilinear_table_interp_unit.sv =====
// bilinear lookup on a uniform log density / log temperature grid of tables.
// in_ch takes one request beat per cycle while in_ch.ready is high: value write,
// phase write, interpolation or nearest-point phase lookup. every request gives
// exactly one beat on out_ch, zeros for writes, in request order.
// cfg_ch writes the grid registers; it is always ready and is to be used
// only while no request is outstanding.
// out_ch.valid rises once an accepted request has reached the result queue;
// throughput, while in_ch.ready is high, is one request per cycle, set by the
// four-copy value memory that returns all four cell corners from one read slot.
// a 16-beat result queue sits behind the pipeline; in_ch.ready stays high while
// fewer than 16 requests are unanswered, so requests keep flowing while a result
// waits. if the receiver stalls, requests stop once 16 are outstanding.
// reset clears the registers to their defaults and empties the queue; the table
// memories are not cleared and entries read before being written are undefined.
module log_grid_bilinear_table_interp_unit
  import lgbi_pkg::*;
#(
  parameter int MAX_DENSITY_POINTS = MAX_DENSITY_POINTS_DEF,
  parameter int MAX_TEMP_POINTS    = MAX_TEMP_POINTS_DEF,
  parameter int NUM_QUANTITIES     = NUM_QUANTITIES_DEF,
  parameter int FRAC_BITS          = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lgbi_chan_if.sink   in_ch,
  lgbi_chan_if.source out_ch,
  lgbi_chan_if.sink   cfg_ch
);

  localparam int MAXP = (MAX_DENSITY_POINTS > MAX_TEMP_POINTS) ?
                        MAX_DENSITY_POINTS : MAX_TEMP_POINTS;
  localparam int IW = $clog2(MAXP);
  localparam int NW = $clog2(MAXP + 1);

  cfg_regs_t cfg_r, cfg_nxt;

  logic       accept, credit_ok;
  in_beat_t   in_r;
  item_ctl_t  ctl_r [PIPE_LAT+1];
  wr_fields_t wr_d_r [4];

  logic [NW-1:0] nd, nt;
  logic [IW-1:0] cell_d, cell_t, near_d, near_t;
  logic [FRAC_BITS:0] frac_d, frac_t;
  logic [FRAC_BITS:0] t_d_r [3];
  logic [FRAC_BITS:0] u_d_r [3];

  logic signed [DATA_W-1:0] corner [4];
  logic [PHASE_W-1:0]       phase_rd;
  logic [PHASE_W-1:0]       ph_d_r [4];
  logic signed [DATA_W-1:0] blend_val;

  out_beat_t  push_beat;
  item_ctl_t  ctl_out;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.data.reg_index)
        CFG_DENSITY_START: cfg_nxt.density_start = $signed(cfg_ch.data.wdata);
        CFG_TEMP_START:    cfg_nxt.temp_start    = $signed(cfg_ch.data.wdata);
        CFG_DENSITY_INV:   cfg_nxt.density_inv   = cfg_ch.data.wdata;
        CFG_TEMP_INV:      cfg_nxt.temp_inv      = cfg_ch.data.wdata;
        CFG_DENSITY_PTS:   cfg_nxt.density_pts   = cfg_ch.data.wdata[PTS_W-1:0];
        CFG_TEMP_PTS:      cfg_nxt.temp_pts      = cfg_ch.data.wdata[PTS_W-1:0];
        CFG_PHASE_PRESENT: cfg_nxt.phase_on      = cfg_ch.data.wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign nd = NW'(clamp_points(cfg_r.density_pts, CLAMP_W'(MAX_DENSITY_POINTS)));
  assign nt = NW'(clamp_points(cfg_r.temp_pts, CLAMP_W'(MAX_TEMP_POINTS)));

  // request pipeline
  assign in_ch.ready = credit_ok;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= PIPE_LAT; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r[0] <= '{valid: accept, req: req_e_t'(in_ch.data.req_type),
                    qty: in_ch.data.quantity};
      for (int k = 1; k <= PIPE_LAT; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_ch.data;
    end
    wr_d_r[0] <= '{entry_index: in_r.entry_index, entry_value: in_r.entry_value,
                   entry_phase: in_r.entry_phase};
    for (int k = 1; k < 4; k++) begin
      wr_d_r[k] <= wr_d_r[k-1];
    end
    t_d_r[0] <= frac_d;
    u_d_r[0] <= frac_t;
    for (int k = 1; k < 3; k++) begin
      t_d_r[k] <= t_d_r[k-1];
      u_d_r[k] <= u_d_r[k-1];
    end
    ph_d_r[0] <= phase_rd;
    for (int k = 1; k < 4; k++) begin
      ph_d_r[k] <= ph_d_r[k-1];
    end
  end

  lgbi_axis_map #(
    .FRAC_BITS (FRAC_BITS),
    .IW        (IW),
    .NW        (NW)
  ) u_axis_density (
    .clk      (clk),
    .q        (in_r.log_density),
    .start    (cfg_r.density_start),
    .step_inv (cfg_r.density_inv),
    .n        (nd),
    .cell_idx (cell_d),
    .frac     (frac_d),
    .near_idx (near_d)
  );

  lgbi_axis_map #(
    .FRAC_BITS (FRAC_BITS),
    .IW        (IW),
    .NW        (NW)
  ) u_axis_temp (
    .clk      (clk),
    .q        (in_r.log_temp),
    .start    (cfg_r.temp_start),
    .step_inv (cfg_r.temp_inv),
    .n        (nt),
    .cell_idx (cell_t),
    .frac     (frac_t),
    .near_idx (near_t)
  );

  lgbi_table_mem #(
    .MAX_DENSITY_POINTS (MAX_DENSITY_POINTS),
    .MAX_TEMP_POINTS    (MAX_TEMP_POINTS),
    .NUM_QUANTITIES     (NUM_QUANTITIES),
    .IW                 (IW),
    .NW                 (NW)
  ) u_table_mem (
    .clk      (clk),
    .ctl_s4   (ctl_r[4]),
    .ctl_s6   (ctl_r[6]),
    .wr_s4    (wr_d_r[3]),
    .cell_d   (cell_d),
    .cell_t   (cell_t),
    .near_d   (near_d),
    .near_t   (near_t),
    .nt       (nt),
    .corner   (corner),
    .phase_rd (phase_rd)
  );

  lgbi_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk    (clk),
    .corner (corner),
    .t      (t_d_r[2]),
    .u      (u_d_r[2]),
    .result (blend_val)
  );

  // result selection
  assign ctl_out = ctl_r[PIPE_LAT];

  always_comb begin
    push_beat = '0;
    case (ctl_out.req)
      REQ_INTERP: begin
        if (32'(ctl_out.qty) < NUM_QUANTITIES) begin
          push_beat.interp_value = blend_val;
        end
      end
      REQ_PHASE: begin
        if (cfg_r.phase_on) begin
          push_beat.phase_code = ph_d_r[3];
        end
      end
      default: push_beat = '0;
    endcase
  end

  lgbi_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (accept),
    .push      (ctl_out.valid),
    .push_beat (push_beat),
    .credit_ok (credit_ok),
    .out_ch    (out_ch)
  );

endmodule
